// File: design/key_edge_autorepeat_macros.svh
// Assertion macros used by the top RTL file of the key autorepeat block.
`ifndef KEY_EDGE_AUTOREPEAT_MACROS_SVH
`define KEY_EDGE_AUTOREPEAT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KEA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define KEA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/kea_pkg.sv
package kea_pkg;

  localparam int unsigned CNT_W = 9;
  localparam int unsigned REG_W = 8;

  localparam logic [CNT_W-1:0] HOLD_MAX = 9'd511;

  typedef enum logic {
    REG_REPEAT_DELAY    = 1'b0,
    REG_REPEAT_INTERVAL = 1'b1
  } kea_reg_t;

  localparam logic [REG_W-1:0] REPEAT_DELAY_RESET    = 8'd40;
  localparam logic [REG_W-1:0] REPEAT_INTERVAL_RESET = 8'd10;

  // One stored entry per key.
  typedef struct packed {
    logic             prev_down;
    logic [CNT_W-1:0] hold;
    logic [CNT_W-1:0] interval;
  } kea_entry_t;

  typedef struct packed {
    logic is_pressed;
    logic press_edge;
    logic release_edge;
    logic repeat_fire;
  } kea_flags_t;

endpackage

// File: design/kea_store.sv
module kea_store #(
  parameter int KEY_COUNT = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(KEY_COUNT)-1:0] rd_addr,
  output kea_pkg::kea_entry_t          rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(KEY_COUNT)-1:0] wr_addr,
  input  kea_pkg::kea_entry_t          wr_data,
  output logic                         busy
);

  localparam int ADDR_W = $clog2(KEY_COUNT);

  kea_pkg::kea_entry_t mem [KEY_COUNT];
  kea_pkg::kea_entry_t mem_q;
  logic [ADDR_W-1:0]   rd_addr_q;

  logic                clearing;
  logic [ADDR_W-1:0]   clr_addr;

  // Copy of the most recent item write, for a read that raced it.
  logic                fwd_valid;
  logic [ADDR_W-1:0]   fwd_addr;
  kea_pkg::kea_entry_t fwd_data;

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      fwd_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == ADDR_W'(KEY_COUNT - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
      if (wr_en && !clearing) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !clearing) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  assign rd_data = (fwd_valid && fwd_addr == rd_addr_q) ? fwd_data : mem_q;
  assign busy    = clearing;

endmodule

// File: design/kea_update.sv
module kea_update (
  input  kea_pkg::kea_entry_t          cur,
  input  logic                         key_down,
  input  logic [kea_pkg::REG_W-1:0]    repeat_delay,
  input  logic [kea_pkg::REG_W-1:0]    repeat_interval,
  output kea_pkg::kea_entry_t          nxt,
  output kea_pkg::kea_flags_t          flags
);

  logic                      press;
  logic                      release_now;
  logic [kea_pkg::CNT_W-1:0] hold_inc;
  logic [kea_pkg::CNT_W-1:0] intv_inc;

  always_comb begin
    press       = !cur.prev_down && key_down;
    release_now = cur.prev_down && !key_down;
    hold_inc    = (cur.hold == kea_pkg::HOLD_MAX) ? cur.hold : cur.hold + 1'b1;
    intv_inc    = cur.interval + 1'b1;

    nxt               = cur;
    nxt.prev_down     = key_down;
    flags.is_pressed  = key_down;
    flags.press_edge  = press;
    flags.release_edge = release_now;
    flags.repeat_fire = 1'b0;

    // An idle key takes neither branch and keeps its counters.
    if (release_now || press) begin
      nxt.hold          = '0;
      nxt.interval      = '0;
      flags.repeat_fire = press;
    end else if (key_down) begin
      nxt.hold = hold_inc;
      // Repeats start only once the hold count has passed the delay.
      if (hold_inc > {1'b0, repeat_delay}) begin
        if (intv_inc > {1'b0, repeat_interval}) begin
          nxt.interval      = '0;
          flags.repeat_fire = 1'b1;
        end else begin
          nxt.interval = intv_inc;
        end
      end
    end
  end

endmodule

// File: design/key_edge_autorepeat.sv
// Per-key edge detector with typematic autorepeat.
// Samples arrive on the sample channel (key_index, key_down) with
// sample_valid/sample_ready; one result per sample leaves on the result
// channel (is_pressed, press_edge, release_edge, repeat_fire) with
// result_valid/result_ready. A key index at or beyond KEY_COUNT gives an
// all-zero result and touches no state.
// Throughput is one sample per cycle without stalls; the key state memory
// has a single read and a single write port, and a write racing the next
// read of the same key is forwarded. After reset the key state memory is
// cleared one entry per cycle, so sample_ready stays low until the clear
// is done. Configuration writes (index 0 repeat_delay, index 1
// repeat_interval) are taken at any time. When the receiver stalls, the
// result register holds, the item in the lookup stage waits, and
// sample_ready drops until the result is taken.
module key_edge_autorepeat #(
  parameter int KEY_COUNT = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [kea_pkg::REG_W-1:0] cfg_data,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  logic [7:0]                key_index,
  input  logic                      key_down,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic                      is_pressed,
  output logic                      press_edge,
  output logic                      release_edge,
  output logic                      repeat_fire
);

`include "key_edge_autorepeat_macros.svh"

  localparam int ADDR_W = $clog2(KEY_COUNT);
  localparam int CMP_W  = (ADDR_W + 1 > 8) ? ADDR_W + 1 : 8;

  logic [kea_pkg::REG_W-1:0] repeat_delay;
  logic [kea_pkg::REG_W-1:0] repeat_interval;

  logic                busy;
  logic                accept;
  logic                in_range;
  logic [ADDR_W-1:0]   rd_addr;
  kea_pkg::kea_entry_t cur;
  kea_pkg::kea_entry_t nxt;
  kea_pkg::kea_flags_t flags;

  logic                s1_valid;
  logic                s1_key_down;
  logic                s1_in_range;
  logic [ADDR_W-1:0]   s1_addr;
  logic                s1_adv;
  logic                wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay    <= kea_pkg::REPEAT_DELAY_RESET;
      repeat_interval <= kea_pkg::REPEAT_INTERVAL_RESET;
    end else if (cfg_write) begin
      unique case (kea_pkg::kea_reg_t'(cfg_index))
        kea_pkg::REG_REPEAT_DELAY:    repeat_delay    <= cfg_data;
        kea_pkg::REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_range     = CMP_W'(key_index) < CMP_W'(KEY_COUNT);
  assign rd_addr      = in_range ? ADDR_W'(key_index) : '0;
  assign s1_adv       = !result_valid || result_ready;
  assign sample_ready = !busy && (!s1_valid || s1_adv);
  assign accept       = sample_valid && sample_ready;
  assign wr_en        = s1_valid && s1_adv && s1_in_range;

  kea_store #(
    .KEY_COUNT(KEY_COUNT)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_data(cur),
    .wr_en  (wr_en),
    .wr_addr(s1_addr),
    .wr_data(nxt),
    .busy   (busy)
  );

  kea_update u_update (
    .cur            (cur),
    .key_down       (s1_key_down),
    .repeat_delay   (repeat_delay),
    .repeat_interval(repeat_interval),
    .nxt            (nxt),
    .flags          (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_down <= key_down;
      s1_in_range <= in_range;
      s1_addr     <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      if (s1_in_range) begin
        is_pressed   <= flags.is_pressed;
        press_edge   <= flags.press_edge;
        release_edge <= flags.release_edge;
        repeat_fire  <= flags.repeat_fire;
      end else begin
        is_pressed   <= 1'b0;
        press_edge   <= 1'b0;
        release_edge <= 1'b0;
        repeat_fire  <= 1'b0;
      end
    end
  end

  `KEA_ASSERT_NOW(a_clear_empty, busy, !s1_valid && !result_valid, "pipeline busy during clear")
  `KEA_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_adv, s1_valid, "stalled request dropped")
  `KEA_ASSERT_NOW(a_press_fires, result_valid && press_edge, repeat_fire && is_pressed, "press edge without repeat pulse")
  `KEA_ASSERT_NOW(a_edges_excl, result_valid, !(press_edge && release_edge), "press and release together")

endmodule

// File: verif/kea_flag_monitor.sv
module kea_flag_monitor #(
  parameter int KEY_COUNT = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [kea_pkg::REG_W-1:0] cfg_data,
  input  logic                      sample_valid,
  input  logic                      sample_ready,
  input  logic [7:0]                key_index,
  input  logic                      key_down,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic                      is_pressed,
  input  logic                      press_edge,
  input  logic                      release_edge,
  input  logic                      repeat_fire,
  output int unsigned               flag_errors,
  output int unsigned               awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]          key;
    kea_pkg::kea_flags_t flags;
  } flag_expect_t;

  kea_pkg::kea_entry_t       key_state [KEY_COUNT];
  logic [kea_pkg::REG_W-1:0] delay_reg;
  logic [kea_pkg::REG_W-1:0] gap_reg;
  flag_expect_t              flags_q [$];
  int unsigned               errors;

  // Advances one key's typematic state by one frame and returns its flags.
  function automatic kea_pkg::kea_flags_t typematic_step(input logic [7:0] k, input logic d);
    kea_pkg::kea_entry_t e;
    kea_pkg::kea_flags_t f;
    f = '0;
    if (int'(k) >= KEY_COUNT) return f;
    e = key_state[k];
    f.is_pressed   = d;
    f.press_edge   = !e.prev_down && d;
    f.release_edge = e.prev_down && !d;
    e.prev_down    = d;
    if (f.release_edge) begin
      e.hold     = '0;
      e.interval = '0;
    end else if (d) begin
      if (f.press_edge) begin
        f.repeat_fire = 1'b1;
        e.hold        = '0;
        e.interval    = '0;
      end else begin
        if (e.hold < kea_pkg::HOLD_MAX) e.hold = e.hold + 1'b1;
        if (e.hold > {1'b0, delay_reg}) begin
          e.interval = e.interval + 1'b1;
          if (e.interval > {1'b0, gap_reg}) begin
            e.interval    = '0;
            f.repeat_fire = 1'b1;
          end
        end
      end
    end
    key_state[k] = e;
    return f;
  endfunction

  always @(posedge clk) begin
    kea_pkg::kea_flags_t seen;
    flag_expect_t        want;
    if (rst) begin
      for (int i = 0; i < KEY_COUNT; i++) key_state[i] = '0;
      delay_reg = kea_pkg::REPEAT_DELAY_RESET;
      gap_reg   = kea_pkg::REPEAT_INTERVAL_RESET;
      flags_q.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        case (kea_pkg::kea_reg_t'(cfg_index))
          kea_pkg::REG_REPEAT_DELAY:    delay_reg = cfg_data;
          kea_pkg::REG_REPEAT_INTERVAL: gap_reg = cfg_data;
          default: ;
        endcase
      end
      // A result always belongs to an earlier request, so compare before queuing.
      if (result_valid && result_ready) begin
        seen = {is_pressed, press_edge, release_edge, repeat_fire};
        if (flags_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with nothing pending: p=%b pe=%b re=%b rf=%b", $realtime,
                     seen.is_pressed, seen.press_edge, seen.release_edge, seen.repeat_fire);
        end else begin
          want = flags_q.pop_front();
          if (seen.is_pressed !== want.flags.is_pressed ||
              seen.press_edge !== want.flags.press_edge ||
              seen.release_edge !== want.flags.release_edge ||
              seen.repeat_fire !== want.flags.repeat_fire) begin
            errors++;
            if (errors <= 10)
              $display("%0t: key %0d expected p=%b pe=%b re=%b rf=%b, got p=%b pe=%b re=%b rf=%b",
                       $realtime, want.key, want.flags.is_pressed, want.flags.press_edge,
                       want.flags.release_edge, want.flags.repeat_fire, seen.is_pressed,
                       seen.press_edge, seen.release_edge, seen.repeat_fire);
          end
        end
      end
      if (sample_valid && sample_ready) begin
        want.key   = key_index;
        want.flags = typematic_step(key_index, key_down);
        flags_q.push_back(want);
      end
    end
    flag_errors <= errors;
    awaited     <= flags_q.size();
  end

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic                      cfg_index;
  logic [kea_pkg::REG_W-1:0] cfg_data;
  logic                      sample_valid;
  logic                      sample_ready;
  logic [7:0]                key_index;
  logic                      key_down;
  logic                      result_valid;
  logic                      result_ready;
  logic                      is_pressed;
  logic                      press_edge;
  logic                      release_edge;
  logic                      repeat_fire;
  int unsigned               flag_errors;
  int unsigned               awaited;
  bit                        calm;
  int unsigned               gap_odds;

  key_edge_autorepeat dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .key_index    (key_index),
    .key_down     (key_down),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_pressed   (is_pressed),
    .press_edge   (press_edge),
    .release_edge (release_edge),
    .repeat_fire  (repeat_fire)
  );

  kea_flag_monitor flag_mon (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .key_index    (key_index),
    .key_down     (key_down),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_pressed   (is_pressed),
    .press_edge   (press_edge),
    .release_edge (release_edge),
    .repeat_fire  (repeat_fire),
    .flag_errors  (flag_errors),
    .awaited      (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("key_edge_autorepeat: mismatch");
    $finish;
  end

  // Result side: random stall bursts, with quiet stretches where it always takes.
  initial begin
    int quiet;
    quiet = 0;
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!calm && quiet == 0 && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      result_ready <= 1'b1;
      if (quiet > 0) quiet--;
      else if ($urandom_range(0, 15) == 0) quiet = $urandom_range(20, 80);
      @(posedge clk);
    end
  end

  task automatic send_sample(input logic [7:0] k, input logic d);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    key_index    <= k;
    key_down     <= d;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
  endtask

  // Waits until every request has its result, then writes both registers.
  task automatic settle_and_configure(input logic [kea_pkg::REG_W-1:0] delay,
                                      input logic [kea_pkg::REG_W-1:0] interval);
    sample_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= kea_pkg::REG_REPEAT_DELAY;
    cfg_data  <= delay;
    @(posedge clk);
    cfg_index <= kea_pkg::REG_REPEAT_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // A few keys pressed and held for runs of frames, with some stray samples mixed in.
  task automatic typing_phase(input logic [kea_pkg::REG_W-1:0] delay,
                              input logic [kea_pkg::REG_W-1:0] interval,
                              input int count, input int unsigned hold_odds);
    logic [7:0] pool [4];
    bit         held [4];
    int         j;
    settle_and_configure(delay, interval);
    case ($urandom_range(0, 2))
      0: gap_odds = 0;
      1: gap_odds = 3;
      default: gap_odds = 10;
    endcase
    pool[0] = 8'd0;
    pool[1] = 8'd255;
    pool[2] = 8'($urandom_range(0, 255));
    pool[3] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 4; i++) held[i] = 1'b0;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        j = $urandom_range(0, 3);
        if ($urandom_range(1, hold_odds) == 1) held[j] = !held[j];
        send_sample(pool[j], held[j]);
      end
    end
  endtask

  // Holds one key long enough for its hold count to saturate.
  task automatic long_hold(input logic [7:0] k);
    settle_and_configure(8'd255, 8'($urandom_range(0, 20)));
    gap_odds = 3;
    repeat (560) begin
      if ($urandom_range(0, 7) == 0)
        send_sample(k ^ 8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
      send_sample(k, 1'b1);
    end
    send_sample(k, 1'b0);
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= kea_pkg::REG_REPEAT_DELAY;
    cfg_data     <= '0;
    sample_valid <= 1'b0;
    key_index    <= '0;
    key_down     <= 1'b0;
    calm     = 1'b0;
    gap_odds = 3;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // With no delay and no interval a held key repeats every frame.
    settle_and_configure(8'd0, 8'd0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd0, 1'b1);
    send_sample(8'd0, 1'b1);
    send_sample(8'd0, 1'b1);
    send_sample(8'd0, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b1);
    send_sample(8'd255, 1'b1);
    send_sample(8'd255, 1'b0);
    send_sample(8'h80, 1'b1);
    send_sample(8'h80, 1'b0);

    // Lowering the interval below a running interval count fires on the next frame.
    settle_and_configure(8'd0, 8'd255);
    send_sample(8'd7, 1'b1);
    repeat (5) send_sample(8'd7, 1'b1);
    settle_and_configure(8'd0, 8'd2);
    send_sample(8'd7, 1'b1);
    send_sample(8'd7, 1'b0);

    typing_phase(8'd0, 8'd0, 200, 8);
    typing_phase(8'd255, 8'd255, 150, 64);
    typing_phase(kea_pkg::REPEAT_DELAY_RESET, kea_pkg::REPEAT_INTERVAL_RESET, 200, 64);
    typing_phase(8'($urandom_range(0, 12)), 8'($urandom_range(0, 6)), 150, 16);
    typing_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 150, 16);
    typing_phase(8'd3, 8'd1, 200, 16);
    typing_phase(8'd255, 8'd0, 100, 32);
    long_hold(8'($urandom_range(0, 255)));

    calm = 1'b1;
    typing_phase(8'd2, 8'd5, 200, 16);

    sample_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (flag_errors == 0 && awaited == 0)
      $display("key_edge_autorepeat: match");
    else
      $display("key_edge_autorepeat: mismatch");
    $finish;
  end

endmodule

// File: key_edge_autorepeat.f
+incdir+design
design/kea_pkg.sv
design/kea_store.sv
design/kea_update.sv
design/key_edge_autorepeat.sv
verif/kea_flag_monitor.sv
verif/tb_top.sv
